>>> rtl/ole_pkg.sv
// Shared widths and request and status codes for the ordered list engine.
package ole_pkg;

  localparam int KindW   = 3;
  localparam int PosW    = 5;
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int FposW   = 4;
  localparam int CountW  = 5;

  localparam logic [KindW-1:0] KIND_PUSH_FRONT  = 3'd0;
  localparam logic [KindW-1:0] KIND_PUSH_BACK   = 3'd1;
  localparam logic [KindW-1:0] KIND_INSERT_AT   = 3'd2;
  localparam logic [KindW-1:0] KIND_REMOVE_VAL  = 3'd3;
  localparam logic [KindW-1:0] KIND_REMOVE_AT   = 3'd4;
  localparam logic [KindW-1:0] KIND_FIND        = 3'd5;
  localparam logic [KindW-1:0] KIND_CLEAR       = 3'd6;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_MISS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  typedef logic signed [ValueW-1:0] value_t;

endpackage

>>> rtl/ole_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ole_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/ordered_list_engine_unit.sv
// Ordered list engine: a bounded list of signed words held in a RAM and walked by a sequencer.
// Requests that touch no entry go straight to the wrap state; a request that searches or shifts
// the list walks it entry by entry; the single RAM port pair moves one entry a cycle.
// One request at a time: the next beat is taken once the result is in the output
// register. Reset clears the entry count and the handshakes; the entry RAM is not cleared, as
// only entries below the count are ever read back.
module ordered_list_engine_unit
  import ole_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [4:0] position, [36:5] item_value, [39:37] zero
  input  logic [2:0]  s_tuser,  // [2:0] kind
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // [3:0] found_position, [35:4] removed_value,
                                // [40:36] entry_count, [47:41] zero
  output logic [1:0]  m_tuser   // [1:0] status
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > PosW) ? CW : PosW;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SEARCH   = 5'b00010,
    S_SHIFT_UP = 5'b00100,
    S_SHIFT_DN = 5'b01000,
    S_WRAP     = 5'b10000
  } state_t;

  state_t state;

  // Request fields as they arrive.
  logic [PosW-1:0]  in_pos;
  value_t           in_value;
  logic [KindW-1:0] in_kind;

  assign in_pos   = s_tdata[PosW-1:0];
  assign in_value = s_tdata[PosW+ValueW-1:PosW];
  assign in_kind  = s_tuser;

  // Held request and working registers.
  logic [KindW-1:0]   kind;
  value_t             value;
  logic [CW-1:0]      cnt;       // entries in the list
  logic [CW-1:0]      at;        // slot that an insertion opens
  logic [CW-1:0]      ptr;       // next entry to read
  logic [CW-1:0]      pidx;      // entry that the read in flight belongs to
  logic               pend;      // a read is in flight and its data arrives this cycle
  logic               grab;      // the data arriving is the entry being removed by index

  // Result staged for the output register.
  logic [StatusW-1:0] res_status;
  logic [CW-1:0]      res_fpos;
  value_t             res_removed;

  // Output register.
  logic [StatusW-1:0] out_status;
  logic [FposW-1:0]   out_fpos;
  value_t             out_removed;
  logic [CountW-1:0]  out_count;

  // RAM ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic accept;
  logic hit;
  logic up_go;
  logic dn_go;
  logic out_free;
  logic ins_bad;
  logic rem_ok;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // In a search, the data arriving is compared against the sought value.
  assign hit   = (state == S_SEARCH) && pend && (ram_rdata == value);
  // Opening a slot walks downwards, moving entry ptr-1 up to ptr while ptr is above the slot.
  assign up_go = (state == S_SHIFT_UP) && (ptr > at);
  // Closing a slot walks upwards, moving entry ptr down to ptr-1 while ptr is inside the list.
  assign dn_go = (state == S_SHIFT_DN) && (ptr < cnt);

  assign ins_bad = CMPW'(in_pos) > CMPW'(cnt);
  assign rem_ok  = CMPW'(in_pos) < CMPW'(cnt);

  ole_ram #(
    .Width (ValueW),
    .Depth (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Read address: the entry to be removed on acceptance, otherwise the walk pointer.
  always_comb begin
    unique case (state)
      S_IDLE:     ram_raddr = AW'(in_pos);
      S_SHIFT_UP: ram_raddr = AW'(ptr - CW'(1));
      default:    ram_raddr = AW'(ptr);
    endcase
  end

  // Write port: a moved entry lands first; the new value goes into the opened slot last.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(pidx);
    ram_wdata = ram_rdata;
    if ((state == S_SHIFT_UP || state == S_SHIFT_DN) && pend) begin
      ram_we = 1'b1;
    end else if (state == S_SHIFT_UP && !up_go) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(at);
      ram_wdata = value;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      grab  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind        <= in_kind;
            value       <= in_value;
            res_status  <= ST_MISS;
            res_fpos    <= '0;
            res_removed <= '0;
            pend        <= 1'b0;
            grab        <= 1'b0;
            ptr         <= '0;
            state       <= S_WRAP;
            unique case (in_kind)
              KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
                if (in_kind == KIND_INSERT_AT && ins_bad) begin
                  res_status <= ST_MISS;
                end else if (CW'(CAPACITY) <= cnt) begin
                  res_status <= ST_FULL;
                end else begin
                  ptr   <= cnt;
                  state <= S_SHIFT_UP;
                  if (in_kind == KIND_PUSH_FRONT) begin
                    at <= '0;
                  end else if (in_kind == KIND_PUSH_BACK) begin
                    at <= cnt;
                  end else begin
                    at <= CW'(in_pos);
                  end
                end
              end
              KIND_REMOVE_VAL, KIND_FIND: begin
                state <= S_SEARCH;
              end
              KIND_REMOVE_AT: begin
                // The RAM is already reading the entry at the position this cycle.
                if (rem_ok) begin
                  ptr   <= CW'(in_pos) + CW'(1);
                  grab  <= 1'b1;
                  state <= S_SHIFT_DN;
                end
              end
              KIND_CLEAR: begin
                cnt        <= '0;
                res_status <= ST_OK;
              end
              default: begin
                res_status <= ST_MISS;
              end
            endcase
          end
        end

        S_SEARCH: begin
          if (hit) begin
            if (kind == KIND_FIND) begin
              res_status <= ST_OK;
              res_fpos   <= pidx;
              pend       <= 1'b0;
              state      <= S_WRAP;
            end else begin
              ptr   <= pidx + CW'(1);
              pend  <= 1'b0;
              state <= S_SHIFT_DN;
            end
          end else if (ptr < cnt) begin
            pend <= 1'b1;
            pidx <= ptr;
            ptr  <= ptr + CW'(1);
          end else begin
            pend  <= 1'b0;
            state <= S_WRAP;
          end
        end

        S_SHIFT_UP: begin
          if (up_go) begin
            pend <= 1'b1;
            pidx <= ptr;
            ptr  <= ptr - CW'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            cnt        <= cnt + CW'(1);
            res_status <= ST_OK;
            state      <= S_WRAP;
          end
        end

        S_SHIFT_DN: begin
          grab <= 1'b0;
          if (grab) begin
            res_removed <= ram_rdata;
          end
          if (dn_go) begin
            pend <= 1'b1;
            pidx <= ptr - CW'(1);
            ptr  <= ptr + CW'(1);
          end else begin
            pend       <= 1'b0;
            cnt        <= cnt - CW'(1);
            res_status <= ST_OK;
            state      <= S_WRAP;
          end
        end

        S_WRAP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded as the sequencer leaves its final state.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_WRAP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRAP && out_free) begin
      out_status  <= res_status;
      out_fpos    <= FposW'(res_fpos);
      out_removed <= res_removed;
      out_count   <= CountW'(cnt);
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {7'b0, out_count, out_removed, out_fpos};

endmodule
